>>> rtl/rc4_stream_cipher_top_macros.svh
// Assertion helpers for the RC4 cipher block.
// RC4_ASSERT checks a property on every clock edge outside reset.
// RC4_ASSERT_NEVER checks that a condition never holds outside reset.
`ifndef RC4_STREAM_CIPHER_TOP_MACROS_SVH
`define RC4_STREAM_CIPHER_TOP_MACROS_SVH
`ifndef SYNTH
`define RC4_ASSERT(label, ck, rn, prop, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);
`define RC4_ASSERT_NEVER(label, ck, rn, cond, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) !(cond)) else $error(msg);
`else
`define RC4_ASSERT(label, ck, rn, prop, msg)
`define RC4_ASSERT_NEVER(label, ck, rn, cond, msg)
`endif
`endif

>>> rtl/rc4_pkg.sv
package rc4_pkg;

    localparam int PERM_SIZE   = 256;
    localparam int PERM_AW     = 8;
    localparam int KEY_MAX_DEF = 256;

    localparam logic [PERM_AW-1:0] PERM_LAST = PERM_AW'(PERM_SIZE - 1);

    localparam logic CMD_KEY  = 1'b0;
    localparam logic CMD_DATA = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KS_INIT,
        ST_KS_RD,
        ST_KS_J,
        ST_KS_W1,
        ST_KS_W2,
        ST_D_RD_I,
        ST_D_RD_J,
        ST_D_W_I,
        ST_D_W_J,
        ST_D_RD_T,
        ST_D_OUT
    } state_t;

    typedef struct packed {
        logic       cmd;
        logic [7:0] byte_in;
        logic       last_key;
    } item_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] byte_out;
    } result_t;

    // Request to the permutation store. A clear returns every entry to identity.
    typedef struct packed {
        logic               clear;
        logic               we;
        logic [PERM_AW-1:0] waddr;
        logic [7:0]         wdata;
        logic [PERM_AW-1:0] raddr;
    } perm_req_t;

endpackage

>>> rtl/rc4_if.sv
interface rc4_in_if;
    import rc4_pkg::*;

    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] byte_in;
    logic       last_key;

    modport source (output valid, output cmd, output byte_in, output last_key, input ready);
    modport sink   (input valid, input cmd, input byte_in, input last_key, output ready);
endinterface

interface rc4_out_if;
    import rc4_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] byte_out;

    modport source (output valid, output byte_out, input ready);
    modport sink   (input valid, input byte_out, output ready);
endinterface

>>> rtl/rc4_ram.sv
module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

>>> rtl/rc4_perm.sv
module rc4_perm (
    input  logic               clk,
    input  logic               rst_n,
    input  rc4_pkg::perm_req_t req,
    output logic [7:0]         rdata
);
    import rc4_pkg::*;

    logic [PERM_SIZE-1:0] valid_reg;
    logic [PERM_SIZE-1:0] valid_next;
    logic                 hit_reg;
    logic [PERM_AW-1:0]   raddr_reg;
    logic [7:0]           ram_rdata;

    rc4_ram #(
        .WIDTH (8),
        .DEPTH (PERM_SIZE)
    ) u_ram (
        .clk   (clk),
        .we    (req.we),
        .waddr (req.waddr),
        .wdata (req.wdata),
        .raddr (req.raddr),
        .rdata (ram_rdata)
    );

    // An entry not written since the last clear still holds its own index.
    always_comb
    begin
        valid_next = valid_reg;
        if (req.clear)
        begin
            valid_next = '0;
        end
        else if (req.we)
        begin
            valid_next[req.waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            hit_reg   <= valid_reg[req.raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        raddr_reg <= req.raddr;
    end

    assign rdata = hit_reg ? ram_rdata : raddr_reg;

endmodule

>>> rtl/rc4_core.sv
module rc4_core #(
    parameter int KEY_MAX = rc4_pkg::KEY_MAX_DEF,
    localparam int KAW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  rc4_pkg::item_t     in_item,
    output logic               in_ready,
    output rc4_pkg::result_t   res,
    input  logic               res_ready,
    output rc4_pkg::perm_req_t perm_req,
    input  logic [7:0]         perm_rdata,
    output logic               key_we,
    output logic [KAW-1:0]     key_waddr,
    output logic [7:0]         key_wdata,
    output logic [KAW-1:0]     key_raddr,
    input  logic [7:0]         key_rdata
);
    import rc4_pkg::*;

    localparam int CW = $clog2(KEY_MAX + 1);

    state_t         state_reg, state_next;
    logic [7:0]     i_reg, i_next;
    logic [7:0]     j_reg, j_next;
    logic [7:0]     k_reg, k_next;
    logic [KAW-1:0] kidx_reg, kidx_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [7:0]     si_reg, si_next;
    logic [7:0]     sj_reg, sj_next;
    logic [7:0]     data_reg, data_next;

    logic [7:0] op_a, op_b, op_c, sum;
    logic       accept;
    logic       count_room;
    logic       kidx_wrap;

    // The one adder that the i, j and k index sums and the keystream sum go through.
    assign sum        = op_a + op_b + op_c;
    assign in_ready   = (state_reg == ST_IDLE);
    assign accept     = in_valid && in_ready;
    assign count_room = count_reg < CW'(KEY_MAX);
    assign kidx_wrap  = (CW'(kidx_reg) + CW'(1)) == count_reg;

    assign key_waddr = count_reg[KAW-1:0];
    assign key_wdata = in_item.byte_in;
    assign key_raddr = kidx_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_item.cmd == CMD_DATA)
                    begin
                        state_next = ST_D_RD_I;
                    end
                    else if (in_item.last_key)
                    begin
                        state_next = ST_KS_INIT;
                    end
                end
            end
            ST_KS_INIT: state_next = ST_KS_RD;
            ST_KS_RD:   state_next = ST_KS_J;
            ST_KS_J:    state_next = ST_KS_W1;
            ST_KS_W1:   state_next = ST_KS_W2;
            ST_KS_W2:   state_next = (k_reg == PERM_LAST) ? ST_IDLE : ST_KS_RD;
            ST_D_RD_I:  state_next = ST_D_RD_J;
            ST_D_RD_J:  state_next = ST_D_W_I;
            ST_D_W_I:   state_next = ST_D_W_J;
            ST_D_W_J:   state_next = ST_D_RD_T;
            ST_D_RD_T:  state_next = ST_D_OUT;
            ST_D_OUT:   state_next = res_ready ? ST_IDLE : ST_D_OUT;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        i_next       = i_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        kidx_next    = kidx_reg;
        count_next   = count_reg;
        si_next      = si_reg;
        sj_next      = sj_reg;
        data_next    = data_reg;
        op_a         = '0;
        op_b         = '0;
        op_c         = '0;
        perm_req     = '0;
        key_we       = 1'b0;
        res.valid    = 1'b0;
        res.byte_out = data_reg ^ perm_rdata;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_item.cmd == CMD_DATA)
                    begin
                        data_next = in_item.byte_in;
                    end
                    else if (count_room)
                    begin
                        key_we     = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                end
            end
            ST_KS_INIT:
            begin
                perm_req.clear = 1'b1;
                j_next         = '0;
                k_next         = '0;
                kidx_next      = '0;
            end
            ST_KS_RD:
            begin
                perm_req.raddr = k_reg;
            end
            ST_KS_J:
            begin
                op_a           = j_reg;
                op_b           = perm_rdata;
                op_c           = key_rdata;
                j_next         = sum;
                si_next        = perm_rdata;
                perm_req.raddr = sum;
            end
            ST_KS_W1:
            begin
                perm_req.we    = 1'b1;
                perm_req.waddr = k_reg;
                perm_req.wdata = perm_rdata;
            end
            ST_KS_W2:
            begin
                perm_req.we    = 1'b1;
                perm_req.waddr = j_reg;
                perm_req.wdata = si_reg;
                op_a           = k_reg;
                op_b           = 8'd1;
                k_next         = sum;
                kidx_next      = kidx_wrap ? '0 : kidx_reg + KAW'(1);
                if (k_reg == PERM_LAST)
                begin
                    i_next     = '0;
                    j_next     = '0;
                    count_next = '0;
                end
            end
            ST_D_RD_I:
            begin
                op_a           = i_reg;
                op_b           = 8'd1;
                i_next         = sum;
                perm_req.raddr = sum;
            end
            ST_D_RD_J:
            begin
                op_a           = j_reg;
                op_b           = perm_rdata;
                j_next         = sum;
                si_next        = perm_rdata;
                perm_req.raddr = sum;
            end
            ST_D_W_I:
            begin
                perm_req.we    = 1'b1;
                perm_req.waddr = i_reg;
                perm_req.wdata = perm_rdata;
                sj_next        = perm_rdata;
            end
            ST_D_W_J:
            begin
                perm_req.we    = 1'b1;
                perm_req.waddr = j_reg;
                perm_req.wdata = si_reg;
            end
            ST_D_RD_T, ST_D_OUT:
            begin
                // The keystream address is held while the result waits.
                op_a           = si_reg;
                op_b           = sj_reg;
                perm_req.raddr = sum;
                res.valid      = (state_reg inside {ST_D_OUT});
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg    <= k_next;
        kidx_reg <= kidx_next;
        si_reg   <= si_next;
        sj_reg   <= sj_next;
        data_reg <= data_next;
    end

endmodule

>>> rtl/rc4_stream_cipher_top.sv
// Channel | Dir | Payload                        | Item meaning
// req     | in  | cmd, byte_in[7:0], last_key    | key byte (cmd 0) or data byte (cmd 1)
// rsp     | out | byte_out[7:0]                  | data byte XOR keystream, data items only
//
// A data item passes through D_RD_I, D_RD_J, D_W_I, D_W_J, D_RD_T and D_OUT before the
// next item is accepted: the permutation RAM has one read and one write port, and the
// reads of S[i], S[j] and S[S[i]+S[j]] plus the two swap writes follow each other through it.
// A key byte without the last mark leaves the core in IDLE; the last key byte runs KS_INIT
// and then 256 schedule steps of KS_RD, KS_J, KS_W1 and KS_W2 on the same RAM ports.
// After reset the permutation reads as identity at once, with no clearing pass.
// The result sits in an output register, so a stalled rsp holds only a later data item.
`include "rc4_stream_cipher_top_macros.svh"

module rc4_stream_cipher_top #(
    parameter int KEY_MAX = rc4_pkg::KEY_MAX_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    rc4_in_if.sink    req,
    rc4_out_if.source rsp
);
    import rc4_pkg::*;

    localparam int KAW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;

    item_t          item;
    result_t        res;
    logic           res_ready;
    logic           core_ready;
    perm_req_t      perm_req;
    logic [7:0]     perm_rdata;
    logic           key_we;
    logic [KAW-1:0] key_waddr;
    logic [7:0]     key_wdata;
    logic [KAW-1:0] key_raddr;
    logic [7:0]     key_rdata;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;

    assign item.cmd      = req.cmd;
    assign item.byte_in  = req.byte_in;
    assign item.last_key = req.last_key;
    assign req.ready     = core_ready;

    // The sequencer: key appends, the key schedule and keystream steps.
    rc4_core #(
        .KEY_MAX (KEY_MAX)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (req.valid),
        .in_item    (item),
        .in_ready   (core_ready),
        .res        (res),
        .res_ready  (res_ready),
        .perm_req   (perm_req),
        .perm_rdata (perm_rdata),
        .key_we     (key_we),
        .key_waddr  (key_waddr),
        .key_wdata  (key_wdata),
        .key_raddr  (key_raddr),
        .key_rdata  (key_rdata)
    );

    // The permutation S, which reads as identity after reset and after each clear.
    rc4_perm u_perm (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (perm_req),
        .rdata (perm_rdata)
    );

    // The key store. Only entries below the stored key length are ever read.
    rc4_ram #(
        .WIDTH (8),
        .DEPTH (KEY_MAX)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    // The output register takes a new result when it is empty or being drained.
    assign res_ready = !out_valid_reg || rsp.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        if (res.valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = res.byte_out;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.byte_out = out_byte_reg;

    // A result handed over by the sequencer shows up in the output register next cycle.
    `RC4_ASSERT(a_result_loaded, clk, rst_n, res.valid && res_ready |=> out_valid_reg && (out_byte_reg == $past(res.byte_out)), "result not loaded into output register")

    // The permutation is never swapped in the cycle a new item is taken.
    `RC4_ASSERT_NEVER(a_no_swap_on_accept, clk, rst_n, perm_req.we && req.valid && req.ready, "permutation write while accepting an item")

    // The key store is written only by an accepted key item.
    `RC4_ASSERT(a_key_write_source, clk, rst_n, key_we |-> req.valid && req.ready && (req.cmd == CMD_KEY), "key store written without a key item")

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps

module tb;
    import rc4_pkg::*;

    // Length of the random part, in items sent after the directed table.
    localparam int RANDOM_ITEMS = 800;
    localparam int NUM_DIRECTED = 24;
    // A last key byte keeps the block busy for a whole key schedule; the drain wait
    // at the end covers one full key schedule with some margin.
    localparam int DRAIN_CYCLES = 1100;

    // One row of the directed table. Where typed is set, want is the byte that
    // must come back; all other rows are checked against the cipher predictor.
    typedef struct packed {
        logic       cmd;
        logic [7:0] byte_val;
        logic       last;
        logic       typed;
        logic [7:0] want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    rc4_in_if  req_if ();
    rc4_out_if rsp_if ();

    rc4_stream_cipher_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // Predictor state: the permutation, the stored key, its length and the
    // two keystream indexes, kept in step with every accepted item.
    logic [7:0]  cipher_perm [PERM_SIZE];
    logic [7:0]  cipher_key [PERM_SIZE];
    int unsigned cipher_key_len;
    logic [7:0]  cipher_i;
    logic [7:0]  cipher_j;

    // Output bytes still to come back, oldest first.
    logic [7:0] expected_bytes [$];

    int unsigned error_count;
    int unsigned items_sent;
    int unsigned data_items;
    int unsigned schedules_run;
    int unsigned overflow_keys;
    int unsigned results_checked;
    int unsigned traffic_phase;
    logic [7:0]  mon_want;

    // Stimulus for the first part of the run. The first three data bytes come
    // from the reset permutation, so their keystream (2, 5, 7) can be typed in.
    // The table then covers a partial key that must not disturb the keystream,
    // data items carrying a stray last mark, a two-byte key, a one-byte key
    // and the common "Key" / "Plaintext" pair.
    stim_row_t directed_rows [NUM_DIRECTED] = '{
        '{CMD_DATA, 8'h00, 1'b0, 1'b1, 8'h02},
        '{CMD_DATA, 8'hFF, 1'b0, 1'b1, 8'hFA},
        '{CMD_DATA, 8'h5A, 1'b1, 1'b1, 8'h5D},
        '{CMD_KEY,  8'hFF, 1'b0, 1'b0, 8'h00},
        '{CMD_DATA, 8'h00, 1'b0, 1'b0, 8'h00},
        '{CMD_DATA, 8'h80, 1'b1, 1'b0, 8'h00},
        '{CMD_KEY,  8'h00, 1'b1, 1'b0, 8'h00},
        '{CMD_DATA, 8'h00, 1'b0, 1'b0, 8'h00},
        '{CMD_DATA, 8'hFF, 1'b0, 1'b0, 8'h00},
        '{CMD_KEY,  8'hFF, 1'b1, 1'b0, 8'h00},
        '{CMD_DATA, 8'h01, 1'b0, 1'b0, 8'h00},
        '{CMD_DATA, 8'hFE, 1'b0, 1'b0, 8'h00},
        '{CMD_KEY,  8'h4B, 1'b0, 1'b0, 8'h00},
        '{CMD_KEY,  8'h65, 1'b0, 1'b0, 8'h00},
        '{CMD_KEY,  8'h79, 1'b1, 1'b0, 8'h00},
        '{CMD_DATA, 8'h50, 1'b0, 1'b0, 8'h00},
        '{CMD_DATA, 8'h6C, 1'b0, 1'b0, 8'h00},
        '{CMD_DATA, 8'h61, 1'b0, 1'b0, 8'h00},
        '{CMD_DATA, 8'h69, 1'b0, 1'b0, 8'h00},
        '{CMD_DATA, 8'h6E, 1'b0, 1'b0, 8'h00},
        '{CMD_DATA, 8'h74, 1'b0, 1'b0, 8'h00},
        '{CMD_DATA, 8'h65, 1'b0, 1'b0, 8'h00},
        '{CMD_DATA, 8'h78, 1'b0, 1'b0, 8'h00},
        '{CMD_DATA, 8'h74, 1'b0, 1'b0, 8'h00}
    };

    // Key schedule over the bytes stored so far. A zero length would act as a
    // single zero byte, but the length is never zero here: the last key byte is stored or the store is full.
    function automatic void schedule_key();
        logic [7:0] acc;
        logic [7:0] kb;
        logic [7:0] t;
        for (int k = 0; k < PERM_SIZE; k++)
        begin
            cipher_perm[k] = 8'(k);
        end
        acc = 8'h00;
        for (int k = 0; k < PERM_SIZE; k++)
        begin
            kb = (cipher_key_len != 0) ? cipher_key[k % cipher_key_len] : 8'h00;
            acc = acc + cipher_perm[k] + kb;
            t = cipher_perm[k];
            cipher_perm[k] = cipher_perm[acc];
            cipher_perm[acc] = t;
        end
        cipher_i = 8'h00;
        cipher_j = 8'h00;
        cipher_key_len = 0;
    endfunction

    // Applies one accepted item to the predictor. Returns 1 when the item
    // produces an output byte, which is then left in res.
    function automatic bit cipher_step(input logic c, input logic [7:0] b,
                                       input logic lk, output logic [7:0] res);
        logic [7:0] t;
        res = 8'h00;
        if (c == CMD_KEY)
        begin
            // Key bytes past the store size are dropped, but a last mark
            // still starts the schedule.
            if (cipher_key_len < KEY_MAX_DEF)
            begin
                cipher_key[cipher_key_len] = b;
                cipher_key_len++;
            end
            if (lk)
            begin
                schedule_key();
            end
            return 1'b0;
        end
        cipher_i = cipher_i + 8'h01;
        cipher_j = cipher_j + cipher_perm[cipher_i];
        t = cipher_perm[cipher_i];
        cipher_perm[cipher_i] = cipher_perm[cipher_j];
        cipher_perm[cipher_j] = t;
        t = cipher_perm[cipher_i] + cipher_perm[cipher_j];
        res = b ^ cipher_perm[t];
        return 1'b1;
    endfunction

    // Idle rates per traffic phase: a slow receiver, then a slow sender,
    // then both at full speed.
    function automatic int unsigned send_idle_pct();
        case (traffic_phase)
            0: return 35;
            1: return 60;
            default: return 0;
        endcase
    endfunction

    function automatic int unsigned recv_idle_pct();
        case (traffic_phase)
            0: return 60;
            1: return 35;
            default: return 0;
        endcase
    endfunction

    // Offers one item and waits for the handshake. Must be entered at the
    // time step of the previous acceptance (or with valid low), so valid only
    // gets one assignment per step.
    task automatic send_item(input logic c, input logic [7:0] b, input logic lk,
                             input logic typed, input logic [7:0] want);
        logic [7:0] predicted;
        bit         produces;
        while ($urandom_range(99) < send_idle_pct())
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid    <= 1'b1;
        req_if.cmd      <= c;
        req_if.byte_in  <= b;
        req_if.last_key <= lk;
        do
        begin
            @(posedge clk);
        end
        while (!req_if.ready);
        items_sent++;
        produces = cipher_step(c, b, lk, predicted);
        if (produces)
        begin
            data_items++;
            expected_bytes.push_back(typed ? want : predicted);
        end
        else if (lk)
        begin
            schedules_run++;
        end
    endtask

    // Drops valid and waits until every outstanding output byte is back. At
    // least the task always waits on the clock, so the next item is driven in a later step.
    task automatic hold_off();
        req_if.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (expected_bytes.size() != 0);
    endtask

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    // Reset is applied once, at the start of the run.
    initial
    begin
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Receiver: ready is rerolled every cycle at the rate of the current phase.
    initial
    begin
        rsp_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct());
        end
    end

    // Result checker: every accepted output byte is matched against the
    // oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            results_checked++;
            if (expected_bytes.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected output byte, expected none, actual %h",
                         $time, rsp_if.byte_out);
            end
            else
            begin
                mon_want = expected_bytes.pop_front();
                if (rsp_if.byte_out !== mon_want)
                begin
                    error_count++;
                    $display("%0t: byte_out mismatch, expected %h, actual %h",
                             $time, mon_want, rsp_if.byte_out);
                end
            end
        end
    end

    // Stimulus: the directed table first, then random bursts. Each burst is
    // normally a complete key followed by a run of data bytes; some bursts
    // skip the key, and stray key bytes without a last mark are mixed into
    // the data so that they pile up into the next key.
    initial
    begin
        int unsigned key_len;
        int unsigned data_len;
        int unsigned burst;
        req_if.valid    = 1'b0;
        req_if.cmd      = CMD_KEY;
        req_if.byte_in  = 8'h00;
        req_if.last_key = 1'b0;
        error_count     = 0;
        items_sent      = 0;
        data_items      = 0;
        schedules_run   = 0;
        overflow_keys   = 0;
        results_checked = 0;
        traffic_phase   = 0;

        // The predictor starts from the identity permutation.
        for (int k = 0; k < PERM_SIZE; k++)
        begin
            cipher_perm[k] = 8'(k);
            cipher_key[k]  = 8'h00;
        end
        cipher_key_len = 0;
        cipher_i       = 8'h00;
        cipher_j       = 8'h00;

        wait (rst_n === 1'b1);
        @(posedge clk);

        for (int r = 0; r < NUM_DIRECTED; r++)
        begin
            send_item(directed_rows[r].cmd, directed_rows[r].byte_val,
                      directed_rows[r].last, directed_rows[r].typed,
                      directed_rows[r].want);
        end

        burst = 0;
        while (items_sent < NUM_DIRECTED + RANDOM_ITEMS)
        begin
            traffic_phase = ((items_sent - NUM_DIRECTED) * 3) / RANDOM_ITEMS;

            // The first burst, and some later ones, start with a drained block.
            if (burst == 0 || $urandom_range(99) < 20)
            begin
                hold_off();
            end

            // One long key runs past the store size so that the surplus bytes
            // are dropped; most keys are short to keep the schedules cheap.
            if (burst == 3)
            begin
                key_len = KEY_MAX_DEF + 2;
            end
            else if ($urandom_range(99) < 15)
            begin
                key_len = 0;
            end
            else if ($urandom_range(99) < 10)
            begin
                key_len = $urandom_range(255, 32);
            end
            else
            begin
                key_len = $urandom_range(16, 1);
            end
            if (key_len > KEY_MAX_DEF)
            begin
                overflow_keys++;
            end
            for (int k = 0; k < key_len; k++)
            begin
                send_item(CMD_KEY, 8'($urandom_range(255)), (k == key_len - 1),
                          1'b0, 8'h00);
            end

            // Data bytes carry a random last mark, which the block must ignore.
            data_len = $urandom_range(60, 4);
            for (int d = 0; d < data_len; d++)
            begin
                if ($urandom_range(99) < 5)
                begin
                    send_item(CMD_KEY, 8'($urandom_range(255)), 1'b0, 1'b0, 8'h00);
                end
                send_item(CMD_DATA, 8'($urandom_range(255)), 1'($urandom_range(1)),
                          1'b0, 8'h00);
            end
            burst++;
        end

        // Wait for the last results, then give a running key schedule time to
        // finish so that any stray output is still caught.
        req_if.valid <= 1'b0;
        while (expected_bytes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d items: %0d data bytes, %0d key schedules, %0d over-long keys.",
                 items_sent, data_items, schedules_run, overflow_keys);
        $display("Checked %0d output bytes, %0d still expected.",
                 results_checked, expected_bytes.size());
        if (error_count == 0 && expected_bytes.size() == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #2000000;
        $display("%0t: timeout, %0d output bytes still expected",
                 $time, expected_bytes.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
